### rtl/gan_pkg.sv
// gan_pkg: shared types and constants of the waypoint-graph next-hop engine
// holds field widths, request kinds, result status codes and the control state type
// no dependencies
package gan_pkg;

    localparam int COORD_W = 15;
    localparam int COST_W  = 23;
    localparam int FSUM_W  = 24;
    localparam int HOPC_W  = 16;
    localparam int CODE_W  = 8;
    localparam int TGT_W   = 6;
    localparam int SQ_W    = 30;
    localparam int DIST_W  = 31;
    localparam int EXT_W   = 11;

    localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

    localparam logic [1:0] KIND_NODE  = 2'd0;
    localparam logic [1:0] KIND_EDGE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic CFG_NODE_COUNT   = 1'b0;
    localparam logic CFG_COLLIDE_SIZE = 1'b1;

    localparam logic [2:0] ST_WRITE_DONE = 3'd0;
    localparam logic [2:0] ST_OFF_NODE   = 3'd1;
    localparam logic [2:0] ST_FOUND      = 3'd2;
    localparam logic [2:0] ST_NO_PATH    = 3'd3;
    localparam logic [2:0] ST_AT_GOAL    = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DONE,
        S_N_RD,
        S_N_SQ,
        S_N_CMP,
        S_CHK,
        S_INIT,
        S_O_RD,
        S_O_EV,
        S_O_END,
        S_E_RD,
        S_E_EV,
        S_E_CMP,
        S_M_HRD,
        S_M_HEV,
        S_M_RD,
        S_M_EV,
        S_M_CMP
    } t_state;

endpackage

### rtl/gan_ram.sv
// gan_ram: simple dual-port synchronous memory, one write and one registered read
// used for the node, edge and search-cost stores; no package dependency
module gan_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/graph_astar_next_hop.sv
// graph_astar_next_hop: waypoint graph store with A* next-hop search
// node and edge writes give their result via the done state and output register
// query: scans read, square and compare each node for the nearest to the point
//   and, on a node, to the goal; each expansion evaluates the open nodes, then
//   each edge; one request at a time; search on one shared read port per memory
// reset (synchronous, active low) restores config and control, no clearing pass
module graph_astar_next_hop #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_node_index,
    input  logic [2:0]  i_edge_slot,
    input  logic [3:0]  i_edge_total,
    input  logic [14:0] i_point_x,
    input  logic [14:0] i_point_y,
    input  logic [14:0] i_goal_x,
    input  logic [14:0] i_goal_y,
    input  logic [5:0]  i_neighbor_index,
    input  logic [15:0] i_hop_cost,
    input  logic [7:0]  i_hop_command,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_command,
    output logic [5:0]  o_next_node
);

    localparam int NAW  = $clog2(MAX_NODES);
    localparam int NCW  = $clog2(MAX_NODES + 1);
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int ED   = MAX_NODES * MAX_EDGES;
    localparam int EAW  = $clog2(ED);
    localparam int CRD  = gan_pkg::COORD_W;
    localparam int NMW  = 2 * CRD + CW;
    localparam int EMW  = gan_pkg::TGT_W + gan_pkg::HOPC_W + gan_pkg::CODE_W;
    localparam int CMW  = gan_pkg::COST_W + NAW;

    gan_pkg::t_state r_state, n_state;

    // configuration
    logic [6:0]     r_node_count;
    logic [CRD-1:0] r_collide;

    // query registers
    logic [CRD-1:0] r_px, r_py, r_gx, r_gy;
    logic           r_sel;
    logic [NCW-1:0] r_idx;
    logic [gan_pkg::SQ_W-1:0]   r_sqx, r_sqy;
    logic [gan_pkg::DIST_W-1:0] r_bd;
    logic [NAW-1:0] r_best, r_src, r_dst, r_cur, r_hop, r_t;
    logic [CRD-1:0] r_bx, r_by, r_dstx, r_hx, r_hy;
    logic [CW-1:0]  r_btot, r_srctot, r_curtot, r_e;
    logic           r_any;
    logic [gan_pkg::FSUM_W-1:0] r_bestf;
    logic [gan_pkg::COST_W-1:0] r_curcost, r_c;
    logic [NAW-1:0] r_curhop;
    logic [gan_pkg::CODE_W-1:0] r_cmd;
    logic [MAX_NODES-1:0] r_open, r_reached;

    // result staging and output register
    logic [2:0]     r_res_status;
    logic [7:0]     r_res_cmd;
    logic [5:0]     r_res_next;
    logic           r_out_valid;
    logic [2:0]     r_status;
    logic [7:0]     r_command;
    logic [5:0]     r_next;

    // memory ports
    logic           node_we, node_re, edge_we, edge_re, cost_we, cost_re;
    logic [NAW-1:0] node_waddr, node_raddr, cost_waddr, cost_raddr;
    logic [EAW-1:0] edge_waddr, edge_raddr;
    logic [NMW-1:0] node_wdata, node_rdata;
    logic [EMW-1:0] edge_wdata, edge_rdata;
    logic [CMW-1:0] cost_wdata, cost_rdata;

    // decoded read data
    logic [CRD-1:0] nd_x, nd_y;
    logic [CW-1:0]  nd_tot;
    logic [gan_pkg::TGT_W-1:0]  ed_tgt;
    logic [gan_pkg::HOPC_W-1:0] ed_cost;
    logic [gan_pkg::CODE_W-1:0] ed_code;
    logic [gan_pkg::COST_W-1:0] cd_cost;
    logic [NAW-1:0] cd_hop;

    assign {nd_x, nd_y, nd_tot}         = node_rdata;
    assign {ed_tgt, ed_cost, ed_code}   = edge_rdata;
    assign {cd_cost, cd_hop}            = cost_rdata;

    // handshakes
    logic in_acc;
    logic out_load;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == gan_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == gan_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    // nodes in use, clamped to the store and to at least one
    logic [gan_pkg::EXT_W-1:0] cnt_ext;
    logic [NCW-1:0] used;
    always_comb begin
        cnt_ext = gan_pkg::EXT_W'(r_node_count);
        if (cnt_ext == '0) begin
            used = NCW'(1);
        end else if (cnt_ext > gan_pkg::EXT_W'(MAX_NODES)) begin
            used = NCW'(MAX_NODES);
        end else begin
            used = NCW'(cnt_ext);
        end
    end

    // distance and cost arithmetic
    logic [CRD-1:0] dx, dy, h;
    logic [gan_pkg::DIST_W-1:0] dsum;
    logic [gan_pkg::FSUM_W-1:0] fval, csum;
    logic [gan_pkg::COST_W-1:0] csat;
    logic tgt_used, on_node, hop_match, last_node, better;
    always_comb begin
        logic [CRD-1:0] qx, qy;
        qx = r_sel ? r_gx : r_px;
        qy = r_sel ? r_gy : r_py;
        dx = (qx > nd_x) ? qx - nd_x : nd_x - qx;
        dy = (qy > nd_y) ? qy - nd_y : nd_y - qy;
        dsum = gan_pkg::DIST_W'(r_sqx) + gan_pkg::DIST_W'(r_sqy);
        h = (r_dstx > nd_x) ? r_dstx - nd_x : nd_x - r_dstx;
        fval = gan_pkg::FSUM_W'(h) + gan_pkg::FSUM_W'(cd_cost);
        csum = gan_pkg::FSUM_W'(r_curcost) + gan_pkg::FSUM_W'(ed_cost);
        csat = (csum > gan_pkg::FSUM_W'(gan_pkg::COST_SAT)) ? gan_pkg::COST_SAT
                                                            : gan_pkg::COST_W'(csum);
        tgt_used = gan_pkg::EXT_W'(ed_tgt) < gan_pkg::EXT_W'(used);
        on_node = (((r_bx > r_px) ? r_bx - r_px : r_px - r_bx) < r_collide) &&
                  (((r_by > r_py) ? r_by - r_py : r_py - r_by) < r_collide);
        hop_match = (nd_x == r_hx) && (nd_y == r_hy);
        last_node = (r_idx == used - NCW'(1));
        better = (r_idx == '0) || (dsum < r_bd);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gan_pkg::S_IDLE:  if (in_acc) begin
                n_state = (i_kind == gan_pkg::KIND_QUERY) ? gan_pkg::S_N_RD
                                                          : gan_pkg::S_DONE;
            end
            gan_pkg::S_DONE:  if (out_load) n_state = gan_pkg::S_IDLE;
            gan_pkg::S_N_RD:  n_state = gan_pkg::S_N_SQ;
            gan_pkg::S_N_SQ:  n_state = gan_pkg::S_N_CMP;
            gan_pkg::S_N_CMP: begin
                if (!last_node) n_state = gan_pkg::S_N_RD;
                else n_state = r_sel ? gan_pkg::S_INIT : gan_pkg::S_CHK;
            end
            gan_pkg::S_CHK:   n_state = on_node ? gan_pkg::S_N_RD : gan_pkg::S_DONE;
            gan_pkg::S_INIT:  n_state = gan_pkg::S_O_RD;
            gan_pkg::S_O_RD:  begin
                if (r_idx >= used) n_state = gan_pkg::S_O_END;
                else if (r_open[r_idx[NAW-1:0]]) n_state = gan_pkg::S_O_EV;
            end
            gan_pkg::S_O_EV:  n_state = gan_pkg::S_O_RD;
            gan_pkg::S_O_END: begin
                if (!r_any) n_state = gan_pkg::S_DONE;
                else if (r_cur == r_dst) begin
                    n_state = (r_src == r_dst) ? gan_pkg::S_DONE : gan_pkg::S_M_HRD;
                end else n_state = gan_pkg::S_E_RD;
            end
            gan_pkg::S_E_RD:  n_state = (r_e >= r_curtot) ? gan_pkg::S_O_RD : gan_pkg::S_E_EV;
            gan_pkg::S_E_EV:  n_state = tgt_used ? gan_pkg::S_E_CMP : gan_pkg::S_E_RD;
            gan_pkg::S_E_CMP: n_state = gan_pkg::S_E_RD;
            gan_pkg::S_M_HRD: n_state = gan_pkg::S_M_HEV;
            gan_pkg::S_M_HEV: n_state = gan_pkg::S_M_RD;
            gan_pkg::S_M_RD:  n_state = (r_e >= r_srctot) ? gan_pkg::S_DONE : gan_pkg::S_M_EV;
            gan_pkg::S_M_EV:  n_state = tgt_used ? gan_pkg::S_M_CMP : gan_pkg::S_M_RD;
            gan_pkg::S_M_CMP: n_state = gan_pkg::S_M_RD;
            default:          n_state = gan_pkg::S_IDLE;
        endcase
    end

    // memory control outputs
    always_comb begin
        logic [CW-1:0] tot_sat;
        tot_sat = (5'(i_edge_total) > 5'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(i_edge_total);
        node_we    = in_acc && (i_kind == gan_pkg::KIND_NODE) &&
                     (gan_pkg::EXT_W'(i_node_index) < gan_pkg::EXT_W'(MAX_NODES));
        node_waddr = NAW'(i_node_index);
        node_wdata = {i_point_x, i_point_y, tot_sat};
        edge_we    = in_acc && (i_kind == gan_pkg::KIND_EDGE) &&
                     (gan_pkg::EXT_W'(i_node_index) < gan_pkg::EXT_W'(MAX_NODES)) &&
                     (5'(i_edge_slot) < 5'(MAX_EDGES));
        edge_waddr = EAW'(i_node_index) * EAW'(MAX_EDGES) + EAW'(i_edge_slot);
        edge_wdata = {i_neighbor_index, i_hop_cost, i_hop_command};
        node_re    = 1'b0;
        node_raddr = r_idx[NAW-1:0];
        edge_re    = 1'b0;
        edge_raddr = EAW'(r_cur) * EAW'(MAX_EDGES) + EAW'(r_e);
        cost_re    = 1'b0;
        cost_raddr = r_idx[NAW-1:0];
        cost_we    = 1'b0;
        cost_waddr = r_t;
        cost_wdata = {r_c, (r_cur == r_src) ? r_t : r_curhop};
        unique case (r_state)
            gan_pkg::S_N_RD: node_re = 1'b1;
            gan_pkg::S_INIT: begin
                cost_we    = 1'b1;
                cost_waddr = r_src;
                cost_wdata = '0;
            end
            gan_pkg::S_O_RD: begin
                node_re = (r_idx < used) && r_open[r_idx[NAW-1:0]];
                cost_re = node_re;
            end
            gan_pkg::S_E_RD: edge_re = (r_e < r_curtot);
            gan_pkg::S_E_EV: begin
                cost_re    = tgt_used;
                cost_raddr = NAW'(ed_tgt);
            end
            gan_pkg::S_E_CMP: cost_we = !r_reached[r_t] || (r_c < cd_cost);
            gan_pkg::S_M_HRD: begin
                node_re    = 1'b1;
                node_raddr = r_hop;
            end
            gan_pkg::S_M_RD: begin
                edge_re    = (r_e < r_srctot);
                edge_raddr = EAW'(r_src) * EAW'(MAX_EDGES) + EAW'(r_e);
            end
            gan_pkg::S_M_EV: begin
                node_re    = tgt_used;
                node_raddr = NAW'(ed_tgt);
            end
            default: ;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gan_pkg::S_IDLE;
            r_node_count <= 7'd1;
            r_collide    <= CRD'(20);
            r_out_valid  <= 1'b0;
            r_open       <= '0;
            r_reached    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == gan_pkg::CFG_NODE_COUNT) r_node_count <= i_cfg_data[6:0];
                else r_collide <= i_cfg_data;
            end
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (out_load) r_out_valid <= 1'b1;
            // open and reached flags
            if (r_state == gan_pkg::S_INIT) begin
                r_open            <= '0;
                r_reached         <= '0;
                r_open[r_src]     <= 1'b1;
                r_reached[r_src]  <= 1'b1;
            end else if (r_state == gan_pkg::S_O_END && r_any && r_cur != r_dst) begin
                r_open[r_cur] <= 1'b0;
            end else if (r_state == gan_pkg::S_E_CMP && cost_we) begin
                r_open[r_t]    <= 1'b1;
                r_reached[r_t] <= 1'b1;
            end
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_status  <= r_res_status;
            r_command <= r_res_cmd;
            r_next    <= r_res_next;
        end
        unique case (r_state)
            gan_pkg::S_IDLE: begin
                r_px  <= i_point_x;
                r_py  <= i_point_y;
                r_gx  <= i_goal_x;
                r_gy  <= i_goal_y;
                r_sel <= 1'b0;
                r_idx <= '0;
                r_res_status <= gan_pkg::ST_WRITE_DONE;
                r_res_cmd    <= '0;
                r_res_next   <= '0;
            end
            gan_pkg::S_N_SQ: begin
                r_sqx <= dx * dx;
                r_sqy <= dy * dy;
            end
            gan_pkg::S_N_CMP: begin
                if (better) begin
                    r_bd   <= dsum;
                    r_best <= r_idx[NAW-1:0];
                    r_bx   <= nd_x;
                    r_by   <= nd_y;
                    r_btot <= nd_tot;
                end
                r_idx <= last_node ? '0 : r_idx + NCW'(1);
            end
            gan_pkg::S_CHK: begin
                r_src    <= r_best;
                r_srctot <= r_btot;
                r_sel    <= 1'b1;
                r_res_status <= gan_pkg::ST_OFF_NODE;
            end
            gan_pkg::S_INIT: begin
                r_dst  <= r_best;
                r_dstx <= r_bx;
                r_any  <= 1'b0;
                r_idx  <= '0;
            end
            gan_pkg::S_O_RD: begin
                if (r_idx < used && !r_open[r_idx[NAW-1:0]]) r_idx <= r_idx + NCW'(1);
            end
            gan_pkg::S_O_EV: begin
                if (!r_any || fval < r_bestf) begin
                    r_bestf   <= fval;
                    r_cur     <= r_idx[NAW-1:0];
                    r_curcost <= cd_cost;
                    r_curhop  <= cd_hop;
                    r_curtot  <= nd_tot;
                end
                r_any <= 1'b1;
                r_idx <= r_idx + NCW'(1);
            end
            gan_pkg::S_O_END: begin
                r_e   <= '0;
                r_hop <= r_curhop;
                if (!r_any) r_res_status <= gan_pkg::ST_NO_PATH;
                else if (r_src == r_dst) r_res_status <= gan_pkg::ST_AT_GOAL;
            end
            gan_pkg::S_E_RD: begin
                if (r_e >= r_curtot) begin
                    r_idx <= '0;
                    r_any <= 1'b0;
                end
            end
            gan_pkg::S_E_EV: begin
                r_t <= NAW'(ed_tgt);
                r_c <= csat;
                if (!tgt_used) r_e <= r_e + CW'(1);
            end
            gan_pkg::S_E_CMP: r_e <= r_e + CW'(1);
            gan_pkg::S_M_HEV: begin
                r_hx  <= nd_x;
                r_hy  <= nd_y;
                r_e   <= '0;
                r_cmd <= '0;
            end
            gan_pkg::S_M_RD: begin
                r_res_status <= gan_pkg::ST_FOUND;
                r_res_cmd    <= r_cmd;
                r_res_next   <= 6'(r_hop);
            end
            gan_pkg::S_M_EV: if (!tgt_used) r_e <= r_e + CW'(1);
            gan_pkg::S_M_CMP: begin
                if (hop_match) r_cmd <= ed_code;
                r_e <= r_e + CW'(1);
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_command   = r_command;
    assign o_next_node = r_next;

    // graph and search stores
    gan_ram #(.W(NMW), .D(MAX_NODES)) u_node_mem (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    gan_ram #(.W(EMW), .D(ED)) u_edge_mem (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    gan_ram #(.W(CMW), .D(MAX_NODES)) u_cost_mem (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (cost_waddr),
        .i_wdata (cost_wdata),
        .i_re    (cost_re),
        .i_raddr (cost_raddr),
        .o_rdata (cost_rdata)
    );

`ifndef SYNTHESIS
    a_open_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open & ~r_reached) == '0)
        else $error("open node that was never reached");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind == gan_pkg::KIND_QUERY) |=> !o_in_ready)
        else $error("new request taken while a query is running");

    a_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != gan_pkg::ST_FOUND) |-> (o_command == '0))
        else $error("command set on a result without a path");

    a_next_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != gan_pkg::ST_FOUND) |-> (o_next_node == '0))
        else $error("next node set on a result without a path");
`endif

endmodule
